[sv/assert_macros.svh]
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: when ante holds, cons holds at the same edge.
`define LLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define LLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/llt_pkg.sv]
// Shared types and constants for the lane line tracker.
// No dependencies; imported by every module of the block.
package llt_pkg;

	// Tracker state codes.
	localparam logic [2:0] ST_TWO        = 3'd0;
	localparam logic [2:0] ST_LEFT       = 3'd1;
	localparam logic [2:0] ST_RIGHT      = 3'd2;
	localparam logic [2:0] ST_LOST_LEFT  = 3'd3;
	localparam logic [2:0] ST_LOST_RIGHT = 3'd4;
	localparam logic [2:0] ST_STOP       = 3'd5;

	// Register map, indexed by word address.
	localparam int          ADDR_W             = 4;
	localparam logic [1:0]  REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [1:0]  REG_LOST_LIMIT     = 2'd1;
	localparam logic [1:0]  REG_CURV_THRESHOLD = 2'd2;
	localparam logic [1:0]  REG_STOP_SPEED     = 2'd3;

	localparam int CFG_WIDTH_W = 12;
	localparam int FRAMES_W    = 16;
	localparam int CURV_W      = 16;
	localparam int SPEED_W     = 10;
	localparam int COUNT_W     = 2;
	localparam int STATE_W     = 3;

	localparam logic [CFG_WIDTH_W-1:0] RST_IMAGE_WIDTH = 12'd640;
	localparam logic [FRAMES_W-1:0]    RST_LOST_LIMIT  = 16'd60;
	localparam logic [14:0]            RST_CURV_THRESH = 15'd77;
	localparam logic [SPEED_W-1:0]     RST_STOP_SPEED  = 10'd300;

	// Configuration register contents.
	typedef struct packed {
		logic [CFG_WIDTH_W-1:0] image_width;
		logic [FRAMES_W-1:0]    lost_frames_limit;
		logic [14:0]            curvature_threshold;
		logic [SPEED_W-1:0]     stop_speed_pwm;
	} llt_cfg_t;

	// Tracker state and its dwell counter.
	typedef struct packed {
		logic [STATE_W-1:0]  state;
		logic [FRAMES_W-1:0] frames;
	} llt_trk_t;

endpackage

[sv/llt_cfg_regs.sv]
// APB-style configuration registers of the lane line tracker.
// Depends on llt_pkg for the register map and reset values.
module llt_cfg_regs
	import llt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output llt_cfg_t          cfg
);

	llt_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width         <= RST_IMAGE_WIDTH;
			cfg_q.lost_frames_limit   <= RST_LOST_LIMIT;
			cfg_q.curvature_threshold <= RST_CURV_THRESH;
			cfg_q.stop_speed_pwm      <= RST_STOP_SPEED;
		end else if (wr_en) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:    cfg_q.image_width         <= pwdata[11:0];
				REG_LOST_LIMIT:     cfg_q.lost_frames_limit   <= pwdata[15:0];
				REG_CURV_THRESHOLD: cfg_q.curvature_threshold <= pwdata[14:0];
				REG_STOP_SPEED:     cfg_q.stop_speed_pwm      <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero-extended.
	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:    prdata = 32'(cfg_q.image_width);
			REG_LOST_LIMIT:     prdata = 32'(cfg_q.lost_frames_limit);
			REG_CURV_THRESHOLD: prdata = 32'(cfg_q.curvature_threshold);
			REG_STOP_SPEED:     prdata = 32'(cfg_q.stop_speed_pwm);
			default:            prdata = 32'd0;
		endcase
	end

endmodule

[sv/llt_step.sv]
// Combinational per-frame step of the lane line tracker: next state and result.
// Depends on llt_pkg for state codes, config and tracker types.
module llt_step
	import llt_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  llt_cfg_t              cfg,
	input  llt_trk_t              trk,
	input  logic [COORD_BITS-1:0] prev_left,
	input  logic [COORD_BITS-1:0] prev_right,
	input  logic [COORD_BITS-1:0] left_center,
	input  logic [COORD_BITS-1:0] right_center,
	input  logic [COUNT_W-1:0]    line_count,
	input  logic [CURV_W-1:0]     curvature,
	input  logic [SPEED_W-1:0]    speed_in,
	output llt_trk_t              trk_nxt,
	output logic [COORD_BITS-1:0] left_bound,
	output logic [COORD_BITS-1:0] right_bound,
	output logic [SPEED_W-1:0]    speed_out
);

	localparam int WX = (COORD_BITS > CFG_WIDTH_W) ? COORD_BITS : CFG_WIDTH_W;

	logic [WX-1:0]         width_ext;
	logic [COORD_BITS-1:0] wd;
	logic [CURV_W-1:0]     cmag;
	logic [COORD_BITS-1:0] dl;
	logic [COORD_BITS-1:0] dr;
	logic                  as_left;
	logic                  two;
	logic [FRAMES_W-1:0]   cnt_up;
	logic                  lost_hit;

	// Image width brought to the coordinate width.
	assign width_ext = WX'(cfg.image_width);
	assign wd        = width_ext[COORD_BITS-1:0];

	// Curvature magnitude; the most negative value maps to 0x8000.
	assign cmag = curvature[CURV_W-1] ? (~curvature + 16'd1) : curvature;

	// Jumps of both centers since the previous frame.
	assign dl = (left_center > prev_left) ? (left_center - prev_left)
	                                      : (prev_left - left_center);
	assign dr = (right_center > prev_right) ? (right_center - prev_right)
	                                        : (prev_right - right_center);

	// Side decision for a single line after two.
	assign as_left = (cmag > CURV_W'(cfg.curvature_threshold)) ? curvature[CURV_W-1]
	                                                          : (dl < dr);

	assign two      = line_count[1];
	assign cnt_up   = (trk.frames == '1) ? trk.frames : trk.frames + 16'd1;
	assign lost_hit = cnt_up >= cfg.lost_frames_limit;

	// Transition and bound selection.
	always_comb begin
		trk_nxt     = trk;
		left_bound  = wd;
		right_bound = '0;
		speed_out   = speed_in;
		if (two) begin
			left_bound  = left_center;
			right_bound = right_center;
			if (trk.state == ST_TWO) begin
				trk_nxt.frames = cnt_up;
			end else begin
				trk_nxt = '{state: ST_TWO, frames: '0};
			end
		end else if (line_count[0]) begin
			case (trk.state)
				ST_TWO: begin
					if (as_left) begin
						left_bound  = left_center;
						right_bound = wd;
						trk_nxt     = '{state: ST_LEFT, frames: '0};
					end else begin
						left_bound  = '0;
						right_bound = right_center;
						trk_nxt     = '{state: ST_RIGHT, frames: '0};
					end
				end
				ST_LEFT: begin
					left_bound     = left_center;
					right_bound    = wd;
					trk_nxt.frames = cnt_up;
				end
				ST_RIGHT: begin
					left_bound     = '0;
					right_bound    = right_center;
					trk_nxt.frames = cnt_up;
				end
				ST_LOST_LEFT: begin
					left_bound  = left_center;
					right_bound = wd;
					trk_nxt     = '{state: ST_LEFT, frames: '0};
				end
				ST_LOST_RIGHT: begin
					left_bound  = '0;
					right_bound = right_center;
					trk_nxt     = '{state: ST_RIGHT, frames: '0};
				end
				default: begin
					trk_nxt.frames = cnt_up;
					speed_out      = cfg.stop_speed_pwm;
				end
			endcase
		end else begin
			case (trk.state)
				ST_TWO: begin
					trk_nxt.frames = cnt_up;
					if (lost_hit) begin
						trk_nxt = '{state: ST_STOP, frames: '0};
					end
				end
				ST_LEFT: begin
					right_bound = wd;
					trk_nxt     = '{state: ST_LOST_LEFT, frames: '0};
				end
				ST_RIGHT: begin
					left_bound = '0;
					trk_nxt    = '{state: ST_LOST_RIGHT, frames: '0};
				end
				ST_LOST_LEFT: begin
					right_bound    = wd;
					trk_nxt.frames = cnt_up;
					if (lost_hit) begin
						trk_nxt = '{state: ST_STOP, frames: '0};
					end
				end
				ST_LOST_RIGHT: begin
					left_bound     = '0;
					trk_nxt.frames = cnt_up;
					if (lost_hit) begin
						trk_nxt = '{state: ST_STOP, frames: '0};
					end
				end
				default: begin
					trk_nxt.frames = cnt_up;
					speed_out      = cfg.stop_speed_pwm;
				end
			endcase
		end
	end

endmodule

[sv/lane_line_tracking_fsm.sv]
// Top level of the lane line tracker: stream ports, pipeline and tracker state.
// Depends on llt_pkg, llt_cfg_regs and llt_step.
//
// The block takes one frame summary per beat and returns one result beat per
// frame, in order. A beat is registered at the input, stepped through the
// tracker in combinational logic and registered again at the output, so one
// beat can be taken in every cycle while the output is not stalled. The
// rate is bounded only by the output register: new beats are taken as long
// as the input stage is empty or can move into the output register.
// Configuration registers should be written only while no beat is in flight.
module lane_line_tracking_fsm
	import llt_pkg::*;
#(
	parameter int COORD_BITS = 12,
	localparam int IN_BITS  = 2 * COORD_BITS + COUNT_W + CURV_W + SPEED_W,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 2 * COORD_BITS + SPEED_W + STATE_W,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// Frame input
	input  logic              s_tvalid,
	output logic              s_tready,
	// left_center, right_center, line_count, curvature, speed_in (low bit up)
	input  logic [IN_W-1:0]   s_tdata,
	// Result output
	output logic              m_tvalid,
	input  logic              m_tready,
	// left_bound, right_bound, speed_out, track_state (low bit up)
	output logic [OUT_W-1:0]  m_tdata,
	// Configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int OFS_RC   = COORD_BITS;
	localparam int OFS_CNT  = 2 * COORD_BITS;
	localparam int OFS_CURV = OFS_CNT + COUNT_W;
	localparam int OFS_SPD  = OFS_CURV + CURV_W;

	llt_cfg_t              cfg;
	llt_trk_t              trk_q;
	llt_trk_t              trk_nxt;
	logic [COORD_BITS-1:0] prev_left_q;
	logic [COORD_BITS-1:0] prev_right_q;

	logic                  valid_s1;
	logic [COORD_BITS-1:0] left_s1;
	logic [COORD_BITS-1:0] right_s1;
	logic [COUNT_W-1:0]    count_s1;
	logic [CURV_W-1:0]     curv_s1;
	logic [SPEED_W-1:0]    speed_s1;

	logic [COORD_BITS-1:0] lb;
	logic [COORD_BITS-1:0] rb;
	logic [SPEED_W-1:0]    spd;

	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_data_q;
	logic                  out_free;
	logic                  step_go;
	logic                  in_beat;

	// Configuration registers.
	llt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Per-frame step logic.
	llt_step #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.cfg          (cfg),
		.trk          (trk_q),
		.prev_left    (prev_left_q),
		.prev_right   (prev_right_q),
		.left_center  (left_s1),
		.right_center (right_s1),
		.line_count   (count_s1),
		.curvature    (curv_s1),
		.speed_in     (speed_s1),
		.trk_nxt      (trk_nxt),
		.left_bound   (lb),
		.right_bound  (rb),
		.speed_out    (spd)
	);

	// Handshake: the input stage moves on whenever the output register frees up.
	assign out_free = !out_valid_q || m_tready;
	assign step_go  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_beat  = s_tvalid && s_tready;

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			left_s1  <= s_tdata[COORD_BITS-1:0];
			right_s1 <= s_tdata[OFS_RC +: COORD_BITS];
			count_s1 <= s_tdata[OFS_CNT +: COUNT_W];
			curv_s1  <= s_tdata[OFS_CURV +: CURV_W];
			speed_s1 <= s_tdata[OFS_SPD +: SPEED_W];
		end
	end

	// Tracker state advances as each beat leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q        <= '{state: ST_TWO, frames: '0};
			prev_left_q  <= '0;
			prev_right_q <= '0;
		end else if (step_go) begin
			trk_q        <= trk_nxt;
			prev_left_q  <= left_s1;
			prev_right_q <= right_s1;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (step_go) begin
			out_data_q <= {trk_nxt.state, spd, rb, lb};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_data_q);

endmodule

[sv/llt_checker.sv]
// Port-level checks for the lane line tracker, bound to the top level.
// Depends on llt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module llt_checker
	import llt_pkg::*;
#(
	parameter int COORD_BITS = 12,
	localparam int OUT_BITS = 2 * COORD_BITS + SPEED_W + STATE_W,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int OFS_ST = 2 * COORD_BITS + SPEED_W;

	logic [COORD_BITS-1:0] lb;
	logic [COORD_BITS-1:0] rb;
	logic [STATE_W-1:0]    st;

	assign lb = m_tdata[COORD_BITS-1:0];
	assign rb = m_tdata[COORD_BITS +: COORD_BITS];
	assign st = m_tdata[OFS_ST +: STATE_W];

	// A stalled result beat holds its value.
	`LLT_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// Lost on the left steers with both bounds at the image width.
	`LLT_ASSERT_IMP(a_lost_left, clk, arst_n, m_tvalid && st == ST_LOST_LEFT, lb == rb, "lost-left bounds differ")

	// Lost on the right steers with both bounds at zero.
	`LLT_ASSERT_IMP(a_lost_right, clk, arst_n, m_tvalid && st == ST_LOST_RIGHT, lb == '0 && rb == '0, "lost-right bounds not zero")

	// With only the right line tracked, the left bound is zero.
	`LLT_ASSERT_IMP(a_right_only, clk, arst_n, m_tvalid && st == ST_RIGHT, lb == '0, "right-only left bound not zero")

endmodule

bind lane_line_tracking_fsm llt_checker #(
	.COORD_BITS (COORD_BITS)
) u_llt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/tb_lane_line_tracking_fsm.sv]
// Self-checking testbench for the lane line tracker: frames are driven on the
// input stream, steering results are predicted in a scoreboard class and compared
// beat by beat. Depends on llt_pkg and lane_line_tracking_fsm.
module tb_lane_line_tracking_fsm;
	import llt_pkg::*;

	localparam int COORD_W     = 12;
	localparam int IN_W        = ((2 * COORD_W + COUNT_W + CURV_W + SPEED_W + 7) / 8) * 8;
	localparam int OUT_W       = ((2 * COORD_W + SPEED_W + STATE_W + 7) / 8) * 8;
	localparam int TIMEOUT     = 2_000_000;
	localparam int RUN_FRAMES  = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 100;

	// One camera frame summary.
	typedef struct {
		logic [COORD_W-1:0]       left_c;
		logic [COORD_W-1:0]       right_c;
		logic [COUNT_W-1:0]       count;
		logic signed [CURV_W-1:0] curv;
		logic [SPEED_W-1:0]       speed;
	} frame_t;

	// One steering result.
	typedef struct {
		logic [COORD_W-1:0] lb;
		logic [COORD_W-1:0] rb;
		logic [SPEED_W-1:0] spd;
		logic [STATE_W-1:0] st;
	} steer_t;

	// Tracks the lane state of the block and holds the steering results still owed.
	class steer_checker;
		logic [COORD_W-1:0]  img_w;
		logic [FRAMES_W-1:0] lost_lim;
		logic [14:0]         curv_thr;
		logic [SPEED_W-1:0]  stop_spd;
		logic [STATE_W-1:0]  trk;
		logic [FRAMES_W-1:0] dwell;
		logic [COORD_W-1:0]  last_lc;
		logic [COORD_W-1:0]  last_rc;
		steer_t              steer_q[$];
		int                  errors;
		int                  seen;

		function new();
			img_w    = RST_IMAGE_WIDTH;
			lost_lim = RST_LOST_LIMIT;
			curv_thr = RST_CURV_THRESH;
			stop_spd = RST_STOP_SPEED;
			trk      = ST_TWO;
			dwell    = '0;
			last_lc  = '0;
			last_rc  = '0;
			errors   = 0;
			seen     = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_IMAGE_WIDTH:    img_w    = val[COORD_W-1:0];
				REG_LOST_LIMIT:     lost_lim = val[FRAMES_W-1:0];
				REG_CURV_THRESHOLD: curv_thr = val[14:0];
				REG_STOP_SPEED:     stop_spd = val[SPEED_W-1:0];
				default: ;
			endcase
		endfunction

		function void count_up();
			if (dwell != '1)
				dwell++;
		endfunction

		function void go_to(logic [STATE_W-1:0] s);
			trk   = s;
			dwell = '0;
		endfunction

		// A frame without lines counts toward the stop limit.
		function void count_lost();
			count_up();
			if (dwell >= lost_lim)
				go_to(ST_STOP);
		endfunction

		function steer_t track_frame(frame_t f);
			steer_t r;
			int     cv;
			int     mag;
			int     dl;
			int     dr;
			bit     as_left;
			cv    = f.curv;
			mag   = (cv < 0) ? -cv : cv;
			r.lb  = img_w;
			r.rb  = '0;
			r.spd = f.speed;
			if (f.count >= 2) begin
				r.lb = f.left_c;
				r.rb = f.right_c;
				if (trk == ST_TWO)
					count_up();
				else
					go_to(ST_TWO);
			end else if (f.count == 1) begin
				case (trk)
					ST_TWO: begin
						// Strong curvature picks the side; else the steadier center wins.
						dl = (f.left_c > last_lc) ? f.left_c - last_lc : last_lc - f.left_c;
						dr = (f.right_c > last_rc) ? f.right_c - last_rc : last_rc - f.right_c;
						if (mag > int'(curv_thr))
							as_left = (cv < 0);
						else
							as_left = (dl < dr);
						if (as_left) begin
							r.lb = f.left_c;
							r.rb = img_w;
							go_to(ST_LEFT);
						end else begin
							r.lb = '0;
							r.rb = f.right_c;
							go_to(ST_RIGHT);
						end
					end
					ST_LEFT: begin
						r.lb = f.left_c;
						r.rb = img_w;
						count_up();
					end
					ST_RIGHT: begin
						r.lb = '0;
						r.rb = f.right_c;
						count_up();
					end
					ST_LOST_LEFT: begin
						r.lb = f.left_c;
						r.rb = img_w;
						go_to(ST_LEFT);
					end
					ST_LOST_RIGHT: begin
						r.lb = '0;
						r.rb = f.right_c;
						go_to(ST_RIGHT);
					end
					default: begin
						count_up();
						r.spd = stop_spd;
					end
				endcase
			end else begin
				case (trk)
					ST_TWO: count_lost();
					ST_LEFT: begin
						r.rb = img_w;
						go_to(ST_LOST_LEFT);
					end
					ST_RIGHT: begin
						r.lb = '0;
						go_to(ST_LOST_RIGHT);
					end
					ST_LOST_LEFT: begin
						r.rb = img_w;
						count_lost();
					end
					ST_LOST_RIGHT: begin
						r.lb = '0;
						count_lost();
					end
					default: begin
						count_up();
						r.spd = stop_spd;
					end
				endcase
			end
			last_lc = f.left_c;
			last_rc = f.right_c;
			r.st    = trk;
			return r;
		endfunction

		function void note_frame(frame_t f);
			steer_q.push_back(track_frame(f));
		endfunction

		function void report(string what);
			$display("tb: result %0d: %s", seen, what);
			errors++;
		endfunction

		function void check_steer(steer_t got);
			steer_t want;
			if (steer_q.size() == 0) begin
				report("result beat with no frame outstanding");
			end else begin
				want = steer_q.pop_front();
				if (got.lb !== want.lb)
					report($sformatf("left_bound got %0d want %0d", got.lb, want.lb));
				if (got.rb !== want.rb)
					report($sformatf("right_bound got %0d want %0d", got.rb, want.rb));
				if (got.spd !== want.spd)
					report($sformatf("speed_out got %0d want %0d", got.spd, want.spd));
				if (got.st !== want.st)
					report($sformatf("track_state got %0d want %0d", got.st, want.st));
			end
			seen++;
		endfunction

		function int pending();
			return steer_q.size();
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;

	bit tx_lazy     = 1'b1;
	bit rx_lazy     = 1'b1;
	bit rx_hold_req = 1'b0;

	steer_checker sb = new();

	lane_line_tracking_fsm #(.COORD_BITS(COORD_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#TIMEOUT;
		$display("lane_line_tracking_fsm: mismatch");
		$finish;
	end

	function automatic frame_t frm(int lc, int rc, int n, int cv, int spd);
		frame_t f;
		f.left_c  = COORD_W'(lc);
		f.right_c = COORD_W'(rc);
		f.count   = COUNT_W'(n);
		f.curv    = CURV_W'(cv);
		f.speed   = SPEED_W'(spd);
		return f;
	endfunction

	// Offer one frame beat, after an optional gap, and wait until it is taken.
	task automatic offer_frame(frame_t f);
		int gap;
		gap = tx_lazy ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= IN_W'({f.speed, f.curv, f.count, f.right_c, f.left_c});
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_frame(f);
	endtask

	// Stop offering and wait until every owed result has arrived.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(int w, int lim, int thr, int spd);
		settle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_LOST_LIMIT, lim);
		write_reg(REG_CURV_THRESHOLD, thr);
		write_reg(REG_STOP_SPEED, spd);
	endtask

	// Random frame with the given line count; centers often stay near the last
	// frame and curvature often sits at the threshold so both side tests get hit.
	function automatic frame_t rand_frame(int n);
		frame_t f;
		int     thr;
		thr = sb.curv_thr;
		f.count = (n == 2 && $urandom_range(0, 7) == 0) ? 2'd3 : COUNT_W'(n);
		if ($urandom_range(0, 2) == 0) begin
			f.left_c  = COORD_W'($urandom);
			f.right_c = COORD_W'($urandom);
		end else begin
			f.left_c  = COORD_W'(int'(sb.last_lc) + $urandom_range(0, 16) - 8);
			f.right_c = COORD_W'(int'(sb.last_rc) + $urandom_range(0, 16) - 8);
		end
		case ($urandom_range(0, 6))
			0: f.curv = CURV_W'(thr);
			1: f.curv = CURV_W'(-thr);
			2: f.curv = CURV_W'(thr + 1);
			3: f.curv = CURV_W'(-thr - 1);
			4: f.curv = ($urandom_range(0, 1) == 1) ? 16'sh8000 : 16'sh7FFF;
			default: f.curv = CURV_W'($urandom);
		endcase
		f.speed = SPEED_W'($urandom);
		return f;
	endfunction

	// Result side: random stalls per beat, one long hold on request.
	initial begin : result_sink
		steer_t got;
		int     gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else begin
				gap = rx_lazy ? $urandom_range(0, 3) : 0;
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			got.lb  = m_tdata[COORD_W-1:0];
			got.rb  = m_tdata[2*COORD_W-1:COORD_W];
			got.spd = m_tdata[2*COORD_W+SPEED_W-1:2*COORD_W];
			got.st  = m_tdata[2*COORD_W+SPEED_W+STATE_W-1:2*COORD_W+SPEED_W];
			sb.check_steer(got);
		end
	end

	// Stimulus: directed cases, a run up to the stop limit, then random phases.
	initial begin : frame_source
		int items;
		int n;
		int run;
		int w;
		int lim;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed walk through every state but stop, with reset settings.
		offer_frame(frm(100, 500, 2, 0, 1023));
		offer_frame(frm(4095, 0, 3, 32767, 0));
		offer_frame(frm(0, 4095, 1, -32768, 512));
		offer_frame(frm(10, 20, 1, 0, 1));
		offer_frame(frm(0, 0, 0, 0, 2));
		offer_frame(frm(0, 0, 0, 0, 3));
		offer_frame(frm(30, 40, 1, 5, 4));
		offer_frame(frm(100, 600, 2, 0, 5));
		offer_frame(frm(120, 610, 1, 32767, 6));
		offer_frame(frm(130, 620, 1, 0, 7));
		offer_frame(frm(0, 0, 0, 0, 8));
		offer_frame(frm(140, 630, 1, -100, 9));
		offer_frame(frm(0, 0, 0, 0, 10));
		offer_frame(frm(200, 300, 2, 0, 11));
		// Threshold equal to curvature: the center jumps decide.
		offer_frame(frm(200, 310, 1, 77, 12));
		offer_frame(frm(50, 60, 2, 0, 13));
		// Equal jumps resolve to the right side.
		offer_frame(frm(60, 50, 1, -77, 14));
		offer_frame(frm(70, 80, 2, 0, 15));

		// A zero limit stops on the first empty frame; stop forces the speed.
		configure(640, 0, 77, 300);
		offer_frame(frm(1, 2, 0, 0, 700));
		offer_frame(frm(3, 4, 1, 0, 701));
		offer_frame(frm(5, 6, 0, 0, 702));
		offer_frame(frm(7, 8, 2, 0, 703));

		// A two-line run as long as the limit, then one empty frame enters stop.
		configure(4095, RUN_FRAMES, 0, 1023);
		tx_lazy = 1'b0;
		rx_lazy = 1'b0;
		for (int i = 0; i < RUN_FRAMES; i++)
			offer_frame(rand_frame(2));
		offer_frame(frm(0, 0, 0, 0, 100));
		offer_frame(frm(9, 9, 2, 0, 101));

		// Random phases, each under its own settings.
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				configure(1, 0, 0, 0);
			end else if (p == 1) begin
				configure(4095, 65535, 32767, 1023);
			end else begin
				case ($urandom_range(0, 3))
					0: w = 1;
					1: w = 4095;
					2: w = 640;
					default: w = $urandom_range(1, 4095);
				endcase
				case ($urandom_range(0, 4))
					0: lim = 0;
					1: lim = 1;
					2: lim = 65535;
					3: lim = $urandom_range(0, 65535);
					default: lim = $urandom_range(2, 12);
				endcase
				configure(w, lim, $urandom_range(0, 32767), $urandom_range(0, 1023));
			end
			if (p == 2)
				rx_hold_req = 1'b1;
			items = 0;
			while (items < PHASE_ITEMS) begin
				// Runs of equal line counts let the tracker settle into each state.
				case ($urandom_range(0, 9))
					0, 1, 2, 3: n = 2;
					4, 5, 6: n = 1;
					default: n = 0;
				endcase
				run = $urandom_range(1, 6);
				for (int k = 0; k < run && items < PHASE_ITEMS; k++) begin
					if (items % 25 == 0) begin
						tx_lazy = $urandom_range(0, 1);
						rx_lazy = $urandom_range(0, 1);
					end
					if (p == 5 && items == PHASE_ITEMS / 2)
						settle();
					offer_frame(rand_frame(n));
					items++;
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("lane_line_tracking_fsm: match");
		else
			$display("lane_line_tracking_fsm: mismatch");
		$finish;
	end

endmodule

[lane_line_tracking_fsm.f]
+incdir+sv
sv/llt_pkg.sv
sv/llt_cfg_regs.sv
sv/llt_step.sv
sv/lane_line_tracking_fsm.sv
sv/llt_checker.sv
tb/sv/tb_lane_line_tracking_fsm.sv
